FILE: rtl/ffea_pkg.sv
package ffea_pkg;

   // default geometry
   localparam int SPACE_UNITS_DEF = 1024;
   localparam int FREE_SLOTS_DEF  = 16;

   // request kinds carried in tuser
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // control sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_UPDATE
   } state_type;

   // per-cell update command
   typedef enum logic [2:0] {
      OP_HOLD,    // keep contents
      OP_SHRINK,  // trim allocated units from the front
      OP_PULL,    // take the next cell's extent (shift down)
      OP_GROW,    // append freed units at the end
      OP_MERGE,   // append freed units and the next cell's extent
      OP_JOIN,    // prepend freed units
      OP_PUSH,    // take the previous cell's extent (shift up)
      OP_PUT      // load the freed extent
   } cell_op_type;

   // compare results captured by each cell during evaluation
   typedef struct packed {
      logic valid;     // cell holds an extent
      logic fit;       // size >= requested length
      logic size_eq;   // size == requested length
      logic below;     // start < freed base
      logic end_gt;    // start + size > freed base
      logic end_eq;    // start + size == freed base
      logic start_lt;  // start < freed end
      logic start_eq;  // start == freed end
   } cell_flag_type;

endpackage

FILE: rtl/ffea_cell.sv
module ffea_cell #(
   parameter int   SPACE_UNITS = ffea_pkg::SPACE_UNITS_DEF,
   parameter logic HEAD        = 1'b0,
   localparam int  AW          = $clog2(SPACE_UNITS),
   localparam int  LW          = AW + 1,
   localparam int  EW          = AW + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    eval,
   input  ffea_pkg::cell_op_type   op,
   input  logic [LW-1:0]           len,
   input  logic [AW-1:0]           base,
   input  logic [EW-1:0]           end_addr,
   input  logic [AW-1:0]           prev_start,
   input  logic [LW-1:0]           prev_size,
   input  logic                    prev_valid,
   input  logic [AW-1:0]           next_start,
   input  logic [LW-1:0]           next_size,
   input  logic                    next_valid,
   output logic [AW-1:0]           start,
   output logic [LW-1:0]           size,
   output logic                    valid,
   output ffea_pkg::cell_flag_type flag
);
   import ffea_pkg::*;

   logic [AW-1:0] start_ff, start_in;
   logic [LW-1:0] size_ff, size_in;
   logic          valid_ff, valid_in;
   cell_flag_type flag_ff, flag_in;
   logic [EW-1:0] pend;

   // local compares against the broadcast request
   always_comb begin
      pend             = EW'(start_ff) + EW'(size_ff);
      flag_in.valid    = valid_ff;
      flag_in.fit      = valid_ff && (size_ff >= len);
      flag_in.size_eq  = size_ff == len;
      flag_in.below    = valid_ff && (start_ff < base);
      flag_in.end_gt   = pend > EW'(base);
      flag_in.end_eq   = pend == EW'(base);
      flag_in.start_lt = EW'(start_ff) < end_addr;
      flag_in.start_eq = EW'(start_ff) == end_addr;
   end

   // next contents from the command and the neighbors
   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      valid_in = valid_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_SHRINK: begin
            start_in = AW'(LW'(start_ff) + len);
            size_in  = size_ff - len;
         end
         OP_PULL: begin
            start_in = next_start;
            size_in  = next_size;
            valid_in = next_valid;
         end
         OP_GROW: begin
            size_in = size_ff + len;
         end
         OP_MERGE: begin
            size_in = size_ff + len + next_size;
         end
         OP_JOIN: begin
            start_in = base;
            size_in  = size_ff + len;
         end
         OP_PUSH: begin
            start_in = prev_start;
            size_in  = prev_size;
            valid_in = prev_valid;
         end
         OP_PUT: begin
            start_in = base;
            size_in  = len;
            valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // extent storage, head cell covers the whole space after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         size_ff  <= HEAD ? LW'(SPACE_UNITS) : '0;
         valid_ff <= HEAD;
      end else begin
         start_ff <= start_in;
         size_ff  <= size_in;
         valid_ff <= valid_in;
      end
   end

   // compare results held for the update cycle
   always_ff @(posedge clock) begin
      if (eval) begin
         flag_ff <= flag_in;
      end
   end

   assign start = start_ff;
   assign size  = size_ff;
   assign valid = valid_ff;
   assign flag  = flag_ff;

endmodule

FILE: rtl/ffea_ctrl.sv
module ffea_ctrl #(
   parameter int  SPACE_UNITS = ffea_pkg::SPACE_UNITS_DEF,
   parameter int  FREE_SLOTS  = ffea_pkg::FREE_SLOTS_DEF,
   localparam int AW          = $clog2(SPACE_UNITS),
   localparam int LW          = AW + 1,
   localparam int EW          = AW + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_func,
   input  logic [LW-1:0]           req_length,
   input  logic [AW-1:0]           req_base,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ffea_pkg::status_type    rsp_status,
   output logic [AW-1:0]           rsp_granted,
   output logic                    eval,
   output ffea_pkg::cell_op_type   op[FREE_SLOTS],
   output logic [LW-1:0]           len,
   output logic [AW-1:0]           base,
   output logic [EW-1:0]           end_addr,
   input  ffea_pkg::cell_flag_type flag[FREE_SLOTS],
   input  logic [AW-1:0]           start[FREE_SLOTS]
);
   import ffea_pkg::*;

   state_type     state_ff, state_in;
   logic          func_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] base_ff;
   logic          rng_ok_ff, rng_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   logic [AW-1:0] granted_ff, granted_in;

   logic          req_accept;
   logic          can_out;
   logic          upd;

   logic [FREE_SLOTS-1:0] fit_sel, fit_ge, pred_sel, succ_sel, at_or_after;
   logic                  any_fit, fit_exact, join_pred, join_succ, bad, full;
   logic [AW-1:0]         fit_start;

   assign end_addr   = EW'(base_ff) + EW'(len_ff);
   assign rng_ok_in  = (len_ff != '0) && (end_addr <= EW'(SPACE_UNITS));
   assign can_out    = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // priority picks over the cell flags: first fit, successor slot, predecessor
   always_comb begin
      logic seen;
      logic lt_prev;
      logic lt_next;
      seen      = 1'b0;
      lt_prev   = 1'b1;
      lt_next   = 1'b0;
      any_fit   = 1'b0;
      fit_exact = 1'b0;
      join_pred = 1'b0;
      join_succ = 1'b0;
      bad       = 1'b0;
      fit_start = '0;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         fit_sel[i]     = flag[i].fit && !seen;
         fit_ge[i]      = flag[i].fit || seen;
         seen           = fit_ge[i];
         succ_sel[i]    = !flag[i].below && lt_prev;
         lt_prev        = flag[i].below;
         at_or_after[i] = !flag[i].below;
      end
      for (int i = FREE_SLOTS - 1; i >= 0; i--) begin
         pred_sel[i] = flag[i].below && !lt_next;
         lt_next     = flag[i].below;
      end
      for (int i = 0; i < FREE_SLOTS; i++) begin
         any_fit   = any_fit || fit_sel[i];
         fit_exact = fit_exact || (fit_sel[i] && flag[i].size_eq);
         fit_start = fit_start | (fit_sel[i] ? start[i] : '0);
         join_pred = join_pred || (pred_sel[i] && flag[i].end_eq);
         join_succ = join_succ || (succ_sel[i] && flag[i].valid && flag[i].start_eq);
         bad       = bad || (pred_sel[i] && flag[i].end_gt)
                         || (succ_sel[i] && flag[i].valid && flag[i].start_lt);
      end
      full = flag[FREE_SLOTS-1].valid;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (can_out) begin
               state_in = req_tvalid ? S_EVAL : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs: handshake, cell commands and result
   always_comb begin
      req_tready = 1'b0;
      eval       = 1'b0;
      upd        = 1'b0;
      status_in  = ST_OK;
      granted_in = '0;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         op[i] = OP_HOLD;
      end
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_EVAL: begin
            eval = 1'b1;
         end
         S_UPDATE: begin
            req_tready = can_out;
            upd        = can_out;
         end
         default: begin
         end
      endcase

      if (upd) begin
         if (func_ff == FUNC_ALLOC) begin
            if ((len_ff != '0) && any_fit) begin
               granted_in = fit_start;
               for (int i = 0; i < FREE_SLOTS; i++) begin
                  if (fit_exact && fit_ge[i]) begin
                     op[i] = OP_PULL;
                  end else if (!fit_exact && fit_sel[i]) begin
                     op[i] = OP_SHRINK;
                  end
               end
            end else begin
               status_in = ST_NOSPACE;
            end
         end else if (rng_ok_ff && !bad) begin
            priority if (join_pred && join_succ) begin
               for (int i = 0; i < FREE_SLOTS; i++) begin
                  if (pred_sel[i]) begin
                     op[i] = OP_MERGE;
                  end else if (at_or_after[i]) begin
                     op[i] = OP_PULL;
                  end
               end
            end else if (join_pred) begin
               for (int i = 0; i < FREE_SLOTS; i++) begin
                  if (pred_sel[i]) begin
                     op[i] = OP_GROW;
                  end
               end
            end else if (join_succ) begin
               for (int i = 0; i < FREE_SLOTS; i++) begin
                  if (succ_sel[i]) begin
                     op[i] = OP_JOIN;
                  end
               end
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               for (int i = 0; i < FREE_SLOTS; i++) begin
                  if (succ_sel[i]) begin
                     op[i] = OP_PUT;
                  end else if (at_or_after[i]) begin
                     op[i] = OP_PUSH;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid_in = upd ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request, range check and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_func;
         len_ff  <= req_length;
         base_ff <= req_base;
      end
      if (eval) begin
         rng_ok_ff <= rng_ok_in;
      end
      if (upd) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
      end
   end

   assign len         = len_ff;
   assign base        = base_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_granted = granted_ff;

endmodule

FILE: rtl/first_fit_extent_allocator_core.sv
// First-fit extent allocator. A row of FREE_SLOTS cells holds the free list
// as (start, size) extents sorted by start, packed from cell 0 up; after reset
// one extent covers all SPACE_UNITS units. An allocate request (tuser 0) takes
// the first extent of at least the requested length and returns its start; a
// free request (tuser 1) returns an extent and merges it with its neighbors,
// or inserts it in order. Status reports ok, no space, or a full list; frees
// of zero length, past the end of the space or overlapping free space are
// dropped with status ok. Each item passes an evaluate step, in which every
// cell compares its extent with the request, and then an update step, in
// which the first-fit and neighbor picks drive each cell to hold, shift or
// update from its neighbor. A new item is taken in the update step of the
// previous one; a held result stalls the update step. There is no clearing
// pass after reset.
module first_fit_extent_allocator_core #(
   parameter int  SPACE_UNITS = ffea_pkg::SPACE_UNITS_DEF,
   parameter int  FREE_SLOTS  = ffea_pkg::FREE_SLOTS_DEF,
   localparam int AW          = $clog2(SPACE_UNITS),
   localparam int LW          = AW + 1,
   localparam int REQ_W       = ((LW + AW + 7) / 8) * 8,
   localparam int RSP_W       = ((2 + AW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // length, base
   input  logic [0:0]       req_tuser,   // func
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, granted
);
   import ffea_pkg::*;

   localparam int EW = AW + 2;

   logic                 eval;
   cell_op_type          op[FREE_SLOTS];
   cell_flag_type        flag[FREE_SLOTS];
   logic [AW-1:0]        start_w[FREE_SLOTS];
   logic [LW-1:0]        size_w[FREE_SLOTS];
   logic                 valid_w[FREE_SLOTS];
   logic [LW-1:0]        len;
   logic [AW-1:0]        base;
   logic [EW-1:0]        end_addr;
   status_type           rsp_status;
   logic [AW-1:0]        rsp_granted;

   ffea_ctrl #(
      .SPACE_UNITS (SPACE_UNITS),
      .FREE_SLOTS  (FREE_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (req_tuser[0]),
      .req_length  (req_tdata[LW-1:0]),
      .req_base    (req_tdata[LW+AW-1:LW]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_granted (rsp_granted),
      .eval        (eval),
      .op          (op),
      .len         (len),
      .base        (base),
      .end_addr    (end_addr),
      .flag        (flag),
      .start       (start_w)
   );

   // chain of extent cells, each linked to both neighbors
   for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_cell
      logic [AW-1:0] prev_start, next_start;
      logic [LW-1:0] prev_size, next_size;
      logic          prev_valid, next_valid;

      if (i == 0) begin : g_first
         assign prev_start = '0;
         assign prev_size  = '0;
         assign prev_valid = 1'b0;
      end else begin : g_mid_prev
         assign prev_start = start_w[i-1];
         assign prev_size  = size_w[i-1];
         assign prev_valid = valid_w[i-1];
      end

      if (i == FREE_SLOTS - 1) begin : g_last
         assign next_start = '0;
         assign next_size  = '0;
         assign next_valid = 1'b0;
      end else begin : g_mid_next
         assign next_start = start_w[i+1];
         assign next_size  = size_w[i+1];
         assign next_valid = valid_w[i+1];
      end

      ffea_cell #(
         .SPACE_UNITS (SPACE_UNITS),
         .HEAD        ((i == 0) ? 1'b1 : 1'b0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .eval       (eval),
         .op         (op[i]),
         .len        (len),
         .base       (base),
         .end_addr   (end_addr),
         .prev_start (prev_start),
         .prev_size  (prev_size),
         .prev_valid (prev_valid),
         .next_start (next_start),
         .next_size  (next_size),
         .next_valid (next_valid),
         .start      (start_w[i]),
         .size       (size_w[i]),
         .valid      (valid_w[i]),
         .flag       (flag[i])
      );
   end

   assign rsp_tdata = RSP_W'({rsp_granted, rsp_status});

endmodule
